FILE: rtl/core/gac_pkg.sv
// ----------------------------------------------------------------------------
// gac_pkg
// shared types and constants of the grid atlas cell allocator
// ----------------------------------------------------------------------------
package gac_pkg;

  localparam int unsigned GacMaxSide = 64;
  localparam int unsigned CfgW       = 11;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned PixW       = 17;
  localparam int unsigned RegIdxW    = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_CELL_W    = 2'd0,
    REG_CELL_H    = 2'd1,
    REG_INIT_COLS = 2'd2,
    REG_INIT_ROWS = 2'd3
  } gac_reg_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } gac_cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REBUILD,
    ST_GROW,
    ST_ROW_PREP,
    ST_ROW_WR,
    ST_COL_PREP,
    ST_COL_RD,
    ST_COL_WR,
    ST_SCAN,
    ST_POP_HC,
    ST_POP_ST,
    ST_POP_DATA,
    ST_MUL_W,
    ST_MUL_H,
    ST_OUT,
    ST_DIV,
    ST_FREE_RD,
    ST_FREE_WR
  } gac_state_e;

endpackage

FILE: rtl/core/gac_ram.sv
// ----------------------------------------------------------------------------
// gac_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module gac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/gac_div.sv
// ----------------------------------------------------------------------------
// gac_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gac_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gac_pkg::CoordW-1:0]  dividend_i,
  input  logic [gac_pkg::CfgW-1:0]    divisor_i,
  output logic                        done_o,
  output logic [gac_pkg::CoordW-1:0]  quot_o
);
  import gac_pkg::*;

  localparam int unsigned StepW = $clog2(CoordW);

  logic                busy_q;
  logic                done_q;
  logic [StepW-1:0]    step_q;
  logic [CfgW-1:0]     rem_q;
  logic [CfgW-1:0]     rem_d;
  logic [CfgW-1:0]     dvs_q;
  logic [CoordW-1:0]   quo_q;
  logic [CfgW:0]       trial;
  logic                qbit;

  // shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[CoordW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? CfgW'(trial - {1'b0, dvs_q}) : trial[CfgW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(CoordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[CoordW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/core/grid_atlas_cell_allocator.sv
// ----------------------------------------------------------------------------
// grid_atlas_cell_allocator
// hands out fixed-size atlas cells from one free-cell queue per grid row,
// growing the grid when every queue has run dry
// ----------------------------------------------------------------------------
//  channel   | handshake           | word
//  ----------+---------------------+------------------------------------------
//  command   | start / busy        | cmd_i, free_x_i, free_y_i
//  result    | done_o strobe       | ok_o, cell_*_o, grew_o, atlas_*_px_o
//  config    | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
//  an allocate scans the rows, pops the first free cell and sizes the atlas;
//  growth adds a row cell by cell, or a column with a read and a write per row
//  a free runs the bit-serial divider (16 steps), then updates the row queue
//  writing either initial size rebuilds the grid, row by row and cell by cell
//  reset leaves an empty grid; busy is high while any word is in flight
//  results cannot be stalled: done_o is a one-cycle strobe
// ----------------------------------------------------------------------------
module grid_atlas_cell_allocator #(
  parameter int unsigned MAX_SIDE = gac_pkg::GacMaxSide
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic [gac_pkg::CoordW-1:0]   free_x_i,
  input  logic [gac_pkg::CoordW-1:0]   free_y_i,
  input  logic                         cfg_we_i,
  input  logic [gac_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [gac_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [gac_pkg::CoordW-1:0]   cell_x_o,
  output logic [gac_pkg::CoordW-1:0]   cell_y_o,
  output logic [gac_pkg::CfgW-1:0]     cell_w_o,
  output logic [gac_pkg::CfgW-1:0]     cell_h_o,
  output logic                         grew_o,
  output logic [gac_pkg::PixW-1:0]     atlas_width_px_o,
  output logic [gac_pkg::PixW-1:0]     atlas_height_px_o
);
  import gac_pkg::*;

  localparam int unsigned SlotW  = $clog2(MAX_SIDE);
  localparam int unsigned CntW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned AddrW  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned HcW    = SlotW + CntW;
  localparam int unsigned EntryW = 2 * CoordW;
  localparam int unsigned InitW  = 7;
  localparam int unsigned WideW  = 9;
  localparam int unsigned ProdW  = CntW + CfgW;

  localparam logic [CntW-1:0]  SideCnt  = CntW'(MAX_SIDE);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_SIDE - 1);

  // flat store address of a slot in a row queue
  function automatic logic [AddrW-1:0] cell_addr(input logic [SlotW-1:0] row,
                                                 input logic [SlotW-1:0] slot);
    cell_addr = AddrW'(AddrW'(row) * AddrW'(MAX_SIDE)) + AddrW'(slot);
  endfunction

  gac_state_e state_q, state_d;

  // control state
  logic [CfgW-1:0]     cw_q, ch_q;
  logic [InitW-1:0]    icols_q, irows_q;
  logic [CntW-1:0]     cols_q, rows_q, tgt_q;
  logic [MAX_SIDE-1:0] valid_q, nonempty_q;
  logic                build_q;

  // payload
  logic [CntW-1:0]     i_q;
  logic [SlotW-1:0]    scan_q, row_q, hc_row_q;
  logic [CoordW-1:0]   x_q, y_q, fx_q, fy_q;
  logic                ok_q, grew_q;
  logic [EntryW-1:0]   entry_q;
  logic [PixW-1:0]     aw_q, ah_q;

  // shared multiplier
  logic [CntW-1:0]     mul_a;
  logic [CfgW-1:0]     mul_b;
  logic [ProdW-1:0]    mul_p;

  // ram ports
  logic                st_we, hc_we;
  logic [AddrW-1:0]    st_waddr, st_raddr;
  logic [EntryW-1:0]   st_wdata, st_rdata;
  logic [SlotW-1:0]    hc_waddr, hc_raddr;
  logic [HcW-1:0]      hc_wdata, hc_rdata;

  // queue bookkeeping of the row last read
  logic [SlotW-1:0]    eff_head, next_head, push_slot;
  logic [CntW-1:0]     eff_cnt;
  logic [CntW:0]       slot_sum;

  logic [CntW-1:0]     sat_cols, sat_rows;
  logic                rebuild_req, row_last, col_last, grid_full;

  logic                div_start, div_done;
  logic [CoordW-1:0]   div_quot;

  // initial sizes saturate at the side limit
  always_comb begin
    sat_cols = (WideW'(icols_q) > WideW'(MAX_SIDE)) ? SideCnt : CntW'(icols_q);
    sat_rows = (WideW'(irows_q) > WideW'(MAX_SIDE)) ? SideCnt : CntW'(irows_q);
  end

  assign rebuild_req = cfg_we_i && (cfg_idx_i == REG_INIT_COLS ||
                                    cfg_idx_i == REG_INIT_ROWS || build_q);
  assign row_last  = (i_q + 1'b1) == cols_q;
  assign col_last  = (i_q + 1'b1) == rows_q;
  assign grid_full = (cols_q > rows_q) ? (rows_q >= SideCnt) : (cols_q >= SideCnt);
  assign div_start = (state_q == ST_IDLE) && start && (cmd_i == CMD_FREE) &&
                     (ch_q != '0);

  // rows never written since the last rebuild read as an empty queue at slot 0
  always_comb begin
    eff_head  = valid_q[hc_row_q] ? hc_rdata[HcW-1:CntW] : '0;
    eff_cnt   = valid_q[hc_row_q] ? hc_rdata[CntW-1:0]   : '0;
    next_head = (eff_head == LastSlot) ? '0 : eff_head + 1'b1;
    slot_sum  = (CntW+1)'(eff_head) + (CntW+1)'(eff_cnt);
    push_slot = (slot_sum >= (CntW+1)'(MAX_SIDE)) ?
                SlotW'(slot_sum - (CntW+1)'(MAX_SIDE)) : SlotW'(slot_sum);
  end

  // rows * cell height for row set-up and atlas height, else columns * cell width
  always_comb begin
    if (state_q == ST_ROW_PREP || state_q == ST_MUL_H) begin
      mul_a = rows_q;
      mul_b = ch_q;
    end else begin
      mul_a = cols_q;
      mul_b = cw_q;
    end
    mul_p = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_FREE) begin
            state_d = (ch_q != '0) ? ST_DIV : ST_IDLE;
          end else begin
            state_d = (|nonempty_q) ? ST_SCAN : ST_GROW;
          end
        end
      end
      ST_REBUILD:  state_d = (sat_cols == '0 || sat_rows == '0) ? ST_IDLE : ST_ROW_PREP;
      ST_GROW: begin
        if (cols_q == '0) begin
          state_d = ST_ROW_PREP;
        end else if (grid_full) begin
          state_d = ST_MUL_W;
        end else begin
          state_d = (cols_q > rows_q) ? ST_ROW_PREP : ST_COL_PREP;
        end
      end
      ST_ROW_PREP: state_d = ST_ROW_WR;
      ST_ROW_WR: begin
        if (row_last) begin
          if (build_q) begin
            state_d = ((rows_q + 1'b1) == tgt_q) ? ST_IDLE : ST_ROW_PREP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_COL_PREP: state_d = ST_COL_RD;
      ST_COL_RD:   state_d = ST_COL_WR;
      ST_COL_WR:   state_d = col_last ? ST_SCAN : ST_COL_RD;
      ST_SCAN:     state_d = nonempty_q[scan_q] ? ST_POP_HC : ST_SCAN;
      ST_POP_HC:   state_d = ST_POP_ST;
      ST_POP_ST:   state_d = ST_POP_DATA;
      ST_POP_DATA: state_d = ST_MUL_W;
      ST_MUL_W:    state_d = ST_MUL_H;
      ST_MUL_H:    state_d = ST_OUT;
      ST_OUT:      state_d = ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_d = (div_quot < CoordW'(rows_q)) ? ST_FREE_RD : ST_IDLE;
        end
      end
      ST_FREE_RD:  state_d = ST_FREE_WR;
      ST_FREE_WR:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
    if (rebuild_req) begin
      state_d = ST_REBUILD;
    end
  end

  // ram controls
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cell_addr(row_q, eff_head);
    st_wdata = {y_q, x_q};
    st_raddr = cell_addr(row_q, eff_head);
    hc_we    = 1'b0;
    hc_waddr = row_q;
    hc_wdata = {eff_head, eff_cnt};
    hc_raddr = (state_q == ST_COL_RD) ? i_q[SlotW-1:0] : row_q;
    unique case (state_q)
      ST_ROW_WR: begin
        st_we    = 1'b1;
        st_waddr = cell_addr(rows_q[SlotW-1:0], i_q[SlotW-1:0]);
        if (row_last) begin
          hc_we    = 1'b1;
          hc_waddr = rows_q[SlotW-1:0];
          hc_wdata = {{SlotW{1'b0}}, cols_q};
        end
      end
      ST_COL_WR: begin
        st_we    = 1'b1;
        st_waddr = cell_addr(i_q[SlotW-1:0], eff_head);
        hc_we    = 1'b1;
        hc_waddr = i_q[SlotW-1:0];
        hc_wdata = {eff_head, CntW'(1)};
      end
      ST_POP_ST: begin
        hc_we    = 1'b1;
        hc_wdata = {next_head, eff_cnt - 1'b1};
      end
      ST_FREE_WR: begin
        if (eff_cnt < SideCnt) begin
          st_we    = 1'b1;
          st_waddr = cell_addr(row_q, push_slot);
          st_wdata = {fy_q, fx_q};
          hc_we    = 1'b1;
          hc_wdata = {eff_head, eff_cnt + 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cw_q       <= CfgW'(16);
      ch_q       <= CfgW'(16);
      icols_q    <= '0;
      irows_q    <= '0;
      cols_q     <= '0;
      rows_q     <= '0;
      tgt_q      <= '0;
      valid_q    <= '0;
      nonempty_q <= '0;
      build_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CELL_W:    cw_q    <= cfg_wdata_i;
          REG_CELL_H:    ch_q    <= cfg_wdata_i;
          REG_INIT_COLS: icols_q <= cfg_wdata_i[InitW-1:0];
          REG_INIT_ROWS: irows_q <= cfg_wdata_i[InitW-1:0];
          default: begin
          end
        endcase
      end
      unique case (state_q)
        ST_REBUILD: begin
          valid_q    <= '0;
          nonempty_q <= '0;
          rows_q     <= '0;
          tgt_q      <= sat_rows;
          if (sat_cols == '0 || sat_rows == '0) begin
            cols_q <= '0;
          end else begin
            cols_q  <= sat_cols;
            build_q <= 1'b1;
          end
        end
        ST_GROW: begin
          // an empty grid becomes one column, then gains row 0
          if (cols_q == '0) begin
            cols_q <= CntW'(1);
          end
        end
        ST_ROW_WR: begin
          if (row_last) begin
            valid_q[rows_q[SlotW-1:0]]    <= 1'b1;
            nonempty_q[rows_q[SlotW-1:0]] <= 1'b1;
            rows_q <= rows_q + 1'b1;
          end
        end
        ST_COL_WR: begin
          valid_q[i_q[SlotW-1:0]]    <= 1'b1;
          nonempty_q[i_q[SlotW-1:0]] <= 1'b1;
          if (col_last) begin
            cols_q <= cols_q + 1'b1;
          end
        end
        ST_POP_ST: begin
          if (eff_cnt == CntW'(1)) begin
            nonempty_q[row_q] <= 1'b0;
          end
        end
        ST_FREE_WR: begin
          if (eff_cnt < SideCnt) begin
            valid_q[row_q]    <= 1'b1;
            nonempty_q[row_q] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (state_d == ST_IDLE) begin
        build_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hc_row_q <= hc_raddr;
    unique case (state_q)
      ST_IDLE: begin
        fx_q    <= free_x_i;
        fy_q    <= free_y_i;
        ok_q    <= 1'b0;
        grew_q  <= 1'b0;
        entry_q <= '0;
        scan_q  <= '0;
      end
      ST_GROW: begin
        grew_q <= (cols_q == '0) || !grid_full;
      end
      ST_ROW_PREP: begin
        y_q <= CoordW'(mul_p);
        x_q <= '0;
        i_q <= '0;
      end
      ST_ROW_WR: begin
        x_q    <= x_q + CoordW'(cw_q);
        i_q    <= i_q + 1'b1;
        scan_q <= '0;
      end
      ST_COL_PREP: begin
        x_q <= CoordW'(mul_p);
        y_q <= '0;
        i_q <= '0;
      end
      ST_COL_WR: begin
        y_q    <= y_q + CoordW'(ch_q);
        i_q    <= i_q + 1'b1;
        scan_q <= '0;
      end
      ST_SCAN: begin
        if (nonempty_q[scan_q]) begin
          row_q <= scan_q;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      ST_POP_DATA: begin
        entry_q <= st_rdata;
        ok_q    <= 1'b1;
      end
      ST_MUL_W: aw_q <= PixW'(mul_p);
      ST_MUL_H: ah_q <= PixW'(mul_p);
      ST_DIV: begin
        row_q <= div_quot[SlotW-1:0];
      end
      default: begin
      end
    endcase
  end

  gac_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_SIDE * MAX_SIDE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  gac_ram #(
    .WIDTH (HcW),
    .DEPTH (MAX_SIDE)
  ) u_head_cnt (
    .clk_i   (clk_i),
    .we_i    (hc_we),
    .waddr_i (hc_waddr),
    .wdata_i (hc_wdata),
    .raddr_i (hc_raddr),
    .rdata_o (hc_rdata)
  );

  // free row is pixel y over cell height
  gac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (free_y_i),
    .divisor_i  (ch_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // result word
  assign busy              = (state_q != ST_IDLE);
  assign done_o            = (state_q == ST_OUT);
  assign ok_o              = ok_q;
  assign cell_x_o          = entry_q[CoordW-1:0];
  assign cell_y_o          = entry_q[EntryW-1:CoordW];
  assign cell_w_o          = ok_q ? cw_q : '0;
  assign cell_h_o          = ok_q ? ch_q : '0;
  assign grew_o            = grew_q;
  assign atlas_width_px_o  = aw_q;
  assign atlas_height_px_o = ah_q;

  // a result is a single-cycle strobe
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // a free never produces a result word
  a_free_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_FREE) |=> !done_o)
    else $error("result after free");

  // grid stays within the side limit
  a_grid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_q <= SideCnt) && (cols_q <= SideCnt))
    else $error("grid exceeds side limit");

  // only rows inside the grid can hold free cells
  a_rows_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q >> rows_q) == '0)
    else $error("free cells outside grid");

endmodule

FILE: sim/grid_atlas_cell_allocator_tb.sv
// ----------------------------------------------------------------------------
// grid_atlas_cell_allocator_tb
// self-checking bench: directed and random allocate/free words, a model of the
// row queues predicts every result word, a monitor compares them field by field
// ----------------------------------------------------------------------------
module grid_atlas_cell_allocator_tb;
  import gac_pkg::*;

  localparam int unsigned MaxSide   = GacMaxSide;
  localparam int unsigned CycleCap  = 4000000;
  localparam int unsigned DrainWait = 400;

  typedef struct packed {
    logic                ok;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [CfgW-1:0]     w;
    logic [CfgW-1:0]     h;
    logic                grew;
    logic [PixW-1:0]     wpx;
    logic [PixW-1:0]     hpx;
  } alloc_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                cmd_i = 1'b0;
  logic [CoordW-1:0]   free_x_i = '0;
  logic [CoordW-1:0]   free_y_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                done_o;
  logic                ok_o;
  logic [CoordW-1:0]   cell_x_o;
  logic [CoordW-1:0]   cell_y_o;
  logic [CfgW-1:0]     cell_w_o;
  logic [CfgW-1:0]     cell_h_o;
  logic                grew_o;
  logic [PixW-1:0]     atlas_width_px_o;
  logic [PixW-1:0]     atlas_height_px_o;

  grid_atlas_cell_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .free_x_i, .free_y_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .ok_o, .cell_x_o,
    .cell_y_o, .cell_w_o, .cell_h_o, .grew_o, .atlas_width_px_o,
    .atlas_height_px_o
  );

  // 20 unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the allocator: per-row free queues and grid size
  // ---------------------------------------------------------------------------
  logic [31:0]       q_store [MaxSide*MaxSide];
  int unsigned       q_head  [MaxSide];
  int unsigned       q_count [MaxSide];
  int unsigned       grid_cols, grid_rows;
  logic [CfgW-1:0]   cfg_cell_w, cfg_cell_h;
  logic [6:0]        cfg_init_cols, cfg_init_rows;

  alloc_word_t       pending_words[$];
  logic [31:0]       cells_held[$];      // cells handed out, candidates for a free
  int unsigned       mismatches, words_checked, words_sent, frees_sent;
  int unsigned       cycles;

  function automatic void queue_push(int unsigned row, logic [15:0] x, logic [15:0] y);
    int unsigned slot;
    if (row >= MaxSide || q_count[row] >= MaxSide) return;
    slot = (q_head[row] + q_count[row]) % MaxSide;
    q_store[row*MaxSide + slot] = {y, x};
    q_count[row]++;
  endfunction

  function automatic void seed_cell(int unsigned col, int unsigned row);
    logic [31:0] px, py;
    px = col * cfg_cell_w;
    py = row * cfg_cell_h;
    queue_push(row, px[15:0], py[15:0]);
  endfunction

  function automatic void rebuild_grid();
    int unsigned c, r;
    c = cfg_init_cols;
    r = cfg_init_rows;
    for (int i = 0; i < MaxSide; i++) begin
      q_head[i]  = 0;
      q_count[i] = 0;
    end
    if (c > MaxSide) c = MaxSide;
    if (r > MaxSide) r = MaxSide;
    if (c == 0 || r == 0) begin
      c = 0;
      r = 0;
    end
    grid_cols = c;
    grid_rows = r;
    for (int j = 0; j < r; j++)
      for (int i = 0; i < c; i++) seed_cell(i, j);
  endfunction

  function automatic bit pop_first_free(output logic [31:0] entry);
    entry = '0;
    for (int r = 0; r < grid_rows && r < MaxSide; r++) begin
      if (q_count[r] != 0) begin
        entry = q_store[r*MaxSide + q_head[r]];
        q_head[r] = (q_head[r] + 1) % MaxSide;
        q_count[r]--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit grow_grid();
    if (grid_cols == 0) begin
      grid_cols = 1;
      grid_rows = 1;
      seed_cell(0, 0);
    end else if (grid_cols > grid_rows) begin
      if (grid_rows >= MaxSide) return 1'b0;
      for (int i = 0; i < grid_cols; i++) seed_cell(i, grid_rows);
      grid_rows++;
    end else begin
      if (grid_cols >= MaxSide) return 1'b0;
      for (int i = 0; i < grid_rows; i++) seed_cell(grid_cols, i);
      grid_cols++;
    end
    return 1'b1;
  endfunction

  function automatic alloc_word_t predict_alloc();
    alloc_word_t o;
    logic [31:0] entry;
    logic [63:0] pw, ph;
    bit got, grew;
    grew = 1'b0;
    got = pop_first_free(entry);
    if (!got && grow_grid()) begin
      grew = 1'b1;
      got  = pop_first_free(entry);
    end
    pw = grid_cols * cfg_cell_w;
    ph = grid_rows * cfg_cell_h;
    o.ok   = got;
    o.x    = got ? entry[15:0] : '0;
    o.y    = got ? entry[31:16] : '0;
    o.w    = got ? cfg_cell_w : '0;
    o.h    = got ? cfg_cell_h : '0;
    o.grew = grew;
    o.wpx  = pw[PixW-1:0];
    o.hpx  = ph[PixW-1:0];
    if (got) cells_held.push_back(entry);
    return o;
  endfunction

  function automatic void apply_free(logic [15:0] fx, logic [15:0] fy);
    int unsigned row;
    if (cfg_cell_h == 0) return;
    row = fy / cfg_cell_h;
    if (row < grid_rows) queue_push(row, fx, fy);
  endfunction

  function automatic void apply_cfg(gac_reg_e idx, logic [CfgW-1:0] val);
    case (idx)
      REG_CELL_W:    cfg_cell_w = val;
      REG_CELL_H:    cfg_cell_h = val;
      REG_INIT_COLS: begin
        cfg_init_cols = val[6:0];
        rebuild_grid();
      end
      REG_INIT_ROWS: begin
        cfg_init_rows = val[6:0];
        rebuild_grid();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result monitor: every done strobe is one word, checked against the oldest
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_word_t got, want;
    if (rst_ni && done_o) begin
      got = '{ok_o, cell_x_o, cell_y_o, cell_w_o, cell_h_o, grew_o,
              atlas_width_px_o, atlas_height_px_o};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: ok=%0d x=%0d y=%0d", got.ok, got.x, got.y);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: want ok=%0d x=%0d y=%0d w=%0d h=%0d grew=%0d ",
                      "wpx=%0d hpx=%0d / got ok=%0d x=%0d y=%0d w=%0d h=%0d grew=%0d ",
                      "wpx=%0d hpx=%0d"},
                     want.ok, want.x, want.y, want.w, want.h, want.grew, want.wpx,
                     want.hpx, got.ok, got.x, got.y, got.w, got.h, got.grew,
                     got.wpx, got.hpx);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_atlas_cell_allocator_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // send one command word and wait until the block is idle again; start is left high
  // so back-to-back words need no idle gap
  task automatic issue_word(gac_cmd_e c, logic [15:0] fx, logic [15:0] fy);
    start    <= 1'b1;
    cmd_i    <= c;
    free_x_i <= fx;
    free_y_i <= fy;
    do @(posedge clk_i); while (busy);
    if (c == CMD_FREE) begin
      apply_free(fx, fy);
      frees_sent++;
    end else begin
      pending_words.push_back(predict_alloc());
    end
    words_sent++;
  endtask

  // sender idling: start dropped for a random run of cycles
  task automatic sender_gap(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start    <= 1'b0;
      cmd_i    <= 1'($urandom);
      free_x_i <= CoordW'($urandom);
      free_y_i <= CoordW'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  // block goes quiet: all words back, then room for a trailing free or rebuild
  task automatic settle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic cfg_write(gac_reg_e idx, logic [CfgW-1:0] val);
    while (busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_cfg(idx, val);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CfgW'($urandom);
    @(posedge clk_i);
  endtask

  task automatic set_geometry(logic [CfgW-1:0] cw, logic [CfgW-1:0] ch,
                              logic [6:0] ic, logic [6:0] ir);
    settle();
    cfg_write(REG_CELL_W, cw);
    cfg_write(REG_CELL_H, ch);
    cfg_write(REG_INIT_COLS, ic);
    cfg_write(REG_INIT_ROWS, ir);
    cells_held.delete();
    while (busy) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // from reset the grid is empty: allocs grow 1x1, then column, then row ...
  task automatic test_growth_from_reset();
    for (int i = 0; i < 6; i++) issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_FREE, 16'd0, 16'd0);           // back onto row 0
    issue_word(CMD_ALLOC, '0, '0);
  endtask

  // drop paths: row outside grid, zero cell height, full queue
  task automatic test_free_drops();
    set_geometry(11'd1024, 11'd1024, 7'd2, 7'd2);
    issue_word(CMD_FREE, 16'hffff, 16'hffff);    // beyond the grid
    issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_FREE, 16'd0, 16'd1023);
    issue_word(CMD_ALLOC, '0, '0);
    set_geometry(11'd1, 11'd0, 7'd3, 7'd3);       // zero height: frees vanish
    issue_word(CMD_FREE, 16'd5, 16'd0);
    issue_word(CMD_ALLOC, '0, '0);
    // oversized initial sizes saturate; queues start full so this free drops
    set_geometry(11'd2047, 11'd2047, 7'd127, 7'd100);
    issue_word(CMD_FREE, 16'h1234, 16'd0);
    issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_ALLOC, '0, '0);
  endtask

  // drain a 64x64 grid completely, then growth has nowhere to go
  task automatic test_grid_full();
    set_geometry(11'd1, 11'd1, 7'd64, 7'd64);
    for (int i = 0; i < MaxSide*MaxSide; i++) issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_FREE, 16'hbeef, 16'd63);
    issue_word(CMD_ALLOC, '0, '0);
    issue_word(CMD_ALLOC, '0, '0);
  endtask

  function automatic logic [CfgW-1:0] pick_cell_size();
    case ($urandom_range(9))
      0:       return 11'd1;
      1:       return 11'd1024;
      2:       return CfgW'($urandom);           // may be 0 or above range
      default: return CfgW'($urandom_range(32, 1));
    endcase
  endfunction

  // random words in phases of geometry and sender idling
  task automatic test_random_traffic(int unsigned total);
    int unsigned per_phase, idle_pct;
    int unsigned k;
    logic [31:0] held;
    per_phase = total / 12;
    for (int ph = 0; ph < 12; ph++) begin
      set_geometry(pick_cell_size(), pick_cell_size(),
                   ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(5)),
                   ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(5)));
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 74;
        default: idle_pct = 17;
      endcase
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(99) < 60) begin
          issue_word(CMD_ALLOC, 16'($urandom), 16'($urandom));
        end else if (cells_held.size() != 0 && $urandom_range(99) < 80) begin
          k    = $urandom_range(cells_held.size() - 1);
          held = cells_held[k];
          cells_held.delete(k);
          issue_word(CMD_FREE, held[15:0], held[31:16]);
        end else begin
          issue_word(CMD_FREE, 16'($urandom), 16'($urandom));
        end
        sender_gap(idle_pct);
      end
    end
  endtask

  initial begin
    cfg_cell_w = 11'd16;
    cfg_cell_h = 11'd16;
    cfg_init_cols = '0;
    cfg_init_rows = '0;
    rebuild_grid();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_growth_from_reset();
    test_free_drops();
    test_grid_full();
    test_random_traffic(1150);

    settle();
    if (pending_words.size() != 0) mismatches += pending_words.size();
    $display("covered %0d words (%0d frees), %0d result words checked",
             words_sent, frees_sent, words_checked);
    $display("geometry sweeps, full-grid exhaustion and dropped frees included");
    if (mismatches == 0) begin
      $display("grid_atlas_cell_allocator_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("grid_atlas_cell_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/gac_pkg.sv
rtl/core/gac_ram.sv
rtl/core/gac_div.sv
rtl/core/grid_atlas_cell_allocator.sv
sim/grid_atlas_cell_allocator_tb.sv
